@@ rtl/dtfr_pkg.sv @@
package dtfr_pkg;

  // default sizes handed to the top level
  localparam int DEF_RING_DEPTH  = 64;
  localparam int DEF_HANDLE_BITS = 32;

  // field widths of the ports
  localparam int STAMP_W  = 64;
  localparam int HANDLE_W = 32;
  localparam int FILL_W   = 7;
  localparam int DISP_W   = 2;
  localparam int PERIOD_W = 8;
  localparam int MAXENT_W = 7;
  localparam int CFG_W    = 8;

  // steps of the bit-serial remainder on the decimation count
  localparam int MOD_STEPS = PERIOD_W;

  // register indexes of the configuration port
  localparam logic CFG_STORE_PERIOD = 1'b0;
  localparam logic CFG_MAX_ENTRIES  = 1'b1;

  // operation codes
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // displacement codes
  localparam logic [DISP_W-1:0] DISP_NONE      = 2'd0;
  localparam logic [DISP_W-1:0] DISP_DROP      = 2'd1;
  localparam logic [DISP_W-1:0] DISP_OVERWRITE = 2'd2;

  // configuration reset values
  localparam logic [PERIOD_W-1:0] RST_STORE_PERIOD = 8'd1;
  localparam logic [MAXENT_W-1:0] RST_MAX_ENTRIES  = 7'd16;

  // control flags of the search token that walks the cell chain
  typedef struct packed {
    logic active;
    logic fetch;
    logic hit;
  } dtfr_tok_t;

endpackage

@@ rtl/dtfr_cell.sv @@
module dtfr_cell import dtfr_pkg::*; #(
  parameter int RING_DEPTH  = DEF_RING_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS,
  parameter int SLOT        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(RING_DEPTH)-1:0] head,
  input  logic [$clog2(RING_DEPTH+1)-1:0] count,
  input  logic                          wr_en,
  input  logic [STAMP_W-1:0]            wr_stamp,
  input  logic [HANDLE_BITS-1:0]        wr_handle,
  input  dtfr_tok_t                     tok_in_ctl,
  input  logic [STAMP_W-1:0]            tok_in_stamp,
  input  logic [HANDLE_BITS-1:0]        tok_in_handle,
  input  logic [$clog2(RING_DEPTH)-1:0] tok_in_best,
  output dtfr_tok_t                     tok_out_ctl,
  output logic [STAMP_W-1:0]            tok_out_stamp,
  output logic [HANDLE_BITS-1:0]        tok_out_handle,
  output logic [$clog2(RING_DEPTH)-1:0] tok_out_best
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH+1);
  localparam logic [IDX_W-1:0] SLOT_I = IDX_W'(SLOT);

  // entry held by this slot
  logic [STAMP_W-1:0]     ent_stamp_r;
  logic [HANDLE_BITS-1:0] ent_handle_r;

  // token stage
  dtfr_tok_t              tok_ctl_r, tok_ctl_nxt;
  logic [STAMP_W-1:0]     tok_stamp_r, tok_stamp_nxt;
  logic [HANDLE_BITS-1:0] tok_handle_r, tok_handle_nxt;
  logic [IDX_W-1:0]       tok_best_r, tok_best_nxt;

  logic [IDX_W:0]   off_wide;
  logic [IDX_W-1:0] off;
  logic             held;
  logic             match;

  // age of this slot counted from the oldest entry
  always_comb begin
    if (SLOT_I >= head) begin
      off_wide = {1'b0, SLOT_I} - {1'b0, head};
    end else begin
      off_wide = {1'b0, SLOT_I} + (IDX_W+1)'(RING_DEPTH) - {1'b0, head};
    end
    off  = off_wide[IDX_W-1:0];
    held = CNT_W'(off) < count;
  end

  // lookup keeps the smallest offset seen so far (the oldest match), fetch grabs the front stamp
  always_comb begin
    tok_ctl_nxt    = tok_in_ctl;
    tok_stamp_nxt  = tok_in_stamp;
    tok_handle_nxt = tok_in_handle;
    tok_best_nxt   = tok_in_best;
    match = held && (ent_stamp_r == tok_in_stamp) &&
            (!tok_in_ctl.hit || (off < tok_in_best));
    if (tok_in_ctl.fetch) begin
      if (held && off == '0) begin
        tok_stamp_nxt   = ent_stamp_r;
        tok_ctl_nxt.hit = 1'b1;
      end
    end else if (match) begin
      tok_ctl_nxt.hit = 1'b1;
      tok_handle_nxt  = ent_handle_r;
      tok_best_nxt    = off;
    end
  end

  // entry write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_stamp_r  <= wr_stamp;
      ent_handle_r <= wr_handle;
    end
  end

  // token hand-on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_ctl_r <= '0;
    end else begin
      tok_ctl_r <= tok_ctl_nxt;
    end
    tok_stamp_r  <= tok_stamp_nxt;
    tok_handle_r <= tok_handle_nxt;
    tok_best_r   <= tok_best_nxt;
  end

  assign tok_out_ctl    = tok_ctl_r;
  assign tok_out_stamp  = tok_stamp_r;
  assign tok_out_handle = tok_handle_r;
  assign tok_out_best   = tok_best_r;

endmodule

@@ rtl/decimating_timestamped_frame_ring.sv @@
// channel  ports                                      direction
// in       in_valid, in_stall, in_operation,          item in
//          in_stamp, in_frame_handle
// out      out_valid, out_stall, out_hit,             item out
//          out_found_handle, out_fill_level, out_displaced
// cfg      cfg_we, cfg_index, cfg_wdata               register write
//
// one item at a time: a store runs the bit-serial remainder on the decimation
// count, and a store that drops the oldest frame then runs the chain pass that
// fetches the new front stamp; a lookup runs a chain pass, the token walking
// one cell per cycle, and a lookup below the oldest stamp skips the pass
// synchronous active-low reset, no clearing pass; in_stall is high while an
// item is in work, and a finished result waits in the output register
module decimating_timestamped_frame_ring import dtfr_pkg::*; #(
  parameter int RING_DEPTH  = DEF_RING_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [STAMP_W-1:0]  in_stamp,
  input  logic [HANDLE_W-1:0] in_frame_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [HANDLE_W-1:0] out_found_handle,
  output logic [FILL_W-1:0]   out_fill_level,
  output logic [DISP_W-1:0]   out_displaced,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH+1);
  localparam int SUM_W = CNT_W + 1;
  localparam int LIM_W = CNT_W + MAXENT_W + 1;
  localparam int MCNT_W = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_PASS,
    S_WAIT
  } state_t;

  state_t state_r;

  // configuration
  logic [PERIOD_W-1:0] store_period_r;
  logic [MAXENT_W-1:0] max_entries_r;

  // ring control
  logic [IDX_W-1:0]    head_r;
  logic [CNT_W-1:0]    count_r;
  logic [PERIOD_W-1:0] dec_r;
  logic [STAMP_W-1:0]  oldest_r;

  // item in work
  logic [STAMP_W-1:0]  key_r;
  logic                fetch_r;
  logic                drop_r;
  logic                launch_r;
  logic                launch_nxt;
  logic                res_hit_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic [DISP_W-1:0]   res_disp_r;

  // remainder unit
  logic [PERIOD_W-1:0] mod_x_r;
  logic [PERIOD_W-1:0] mod_rem_r;
  logic [MCNT_W-1:0]   mod_cnt_r;
  logic [PERIOD_W:0]   mod_t;
  logic [PERIOD_W:0]   mod_step;
  logic [PERIOD_W-1:0] per_eff;

  // output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [HANDLE_W-1:0] out_found_handle_r;
  logic [FILL_W-1:0]   out_fill_level_r;
  logic [DISP_W-1:0]   out_displaced_r;

  // store decode
  logic                accept;
  logic                store_go;
  logic                keep;
  logic                overwrite;
  logic                drop;
  logic [MAXENT_W-1:0] eff_max;
  logic [LIM_W-1:0]    lim;
  logic [SUM_W-1:0]    wsum;
  logic [SUM_W-1:0]    wslot_full;
  logic [IDX_W-1:0]    wr_slot;
  logic [IDX_W-1:0]    head_inc;
  logic [CNT_W-1:0]    count_nxt;
  logic [HANDLE_BITS-1:0] wr_handle;

  // chain taps
  dtfr_tok_t              tap_ctl    [RING_DEPTH+1];
  logic [STAMP_W-1:0]     tap_stamp  [RING_DEPTH+1];
  logic [HANDLE_BITS-1:0] tap_handle [RING_DEPTH+1];
  logic [IDX_W-1:0]       tap_best   [RING_DEPTH+1];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign store_go = accept && (in_operation == OP_STORE);

  // token launch for a lookup pass or for the front stamp fetch after a drop
  assign launch_nxt = (accept && (in_operation == OP_LOOKUP) && (in_stamp >= oldest_r)) ||
                      ((state_r == S_MOD) && drop_r &&
                       (mod_cnt_r == MCNT_W'(MOD_STEPS - 1)));

  // choice of action for a store
  always_comb begin
    eff_max   = (max_entries_r == '0) ? MAXENT_W'(1) : max_entries_r;
    lim       = (LIM_W'(eff_max) > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH)
                                                       : LIM_W'(eff_max);
    keep      = (dec_r == '0);
    overwrite = !keep && (count_r != '0);
    drop      = keep && ((LIM_W'(count_r) + LIM_W'(1)) > lim);
    wsum      = SUM_W'(head_r) + SUM_W'(count_r) - (overwrite ? SUM_W'(1) : '0);
    wslot_full = (wsum >= SUM_W'(RING_DEPTH)) ? wsum - SUM_W'(RING_DEPTH) : wsum;
    wr_slot   = wslot_full[IDX_W-1:0];
    head_inc  = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
    count_nxt = (overwrite || drop) ? count_r : count_r + CNT_W'(1);
    wr_handle = HANDLE_BITS'(in_frame_handle);
  end

  // one step of the restoring remainder
  always_comb begin
    per_eff  = (store_period_r == '0) ? PERIOD_W'(1) : store_period_r;
    mod_t    = {mod_rem_r, mod_x_r[PERIOD_W-1]};
    mod_step = (mod_t >= {1'b0, per_eff}) ? mod_t - {1'b0, per_eff} : mod_t;
  end

  // token injected at the first cell
  assign tap_ctl[0]    = '{active: launch_r, fetch: fetch_r, hit: 1'b0};
  assign tap_stamp[0]  = key_r;
  assign tap_handle[0] = '0;
  assign tap_best[0]   = '0;

  // row of slot cells
  for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
    dtfr_cell #(
      .RING_DEPTH  (RING_DEPTH),
      .HANDLE_BITS (HANDLE_BITS),
      .SLOT        (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .head           (head_r),
      .count          (count_r),
      .wr_en          (store_go && (wr_slot == IDX_W'(g))),
      .wr_stamp       (in_stamp),
      .wr_handle      (wr_handle),
      .tok_in_ctl     (tap_ctl[g]),
      .tok_in_stamp   (tap_stamp[g]),
      .tok_in_handle  (tap_handle[g]),
      .tok_in_best    (tap_best[g]),
      .tok_out_ctl    (tap_ctl[g+1]),
      .tok_out_stamp  (tap_stamp[g+1]),
      .tok_out_handle (tap_handle[g+1]),
      .tok_out_best   (tap_best[g+1])
    );
  end

  // sequencer, ring control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      store_period_r     <= RST_STORE_PERIOD;
      max_entries_r      <= RST_MAX_ENTRIES;
      head_r             <= '0;
      count_r            <= '0;
      dec_r              <= '0;
      oldest_r           <= '0;
      key_r              <= '0;
      fetch_r            <= 1'b0;
      drop_r             <= 1'b0;
      launch_r           <= 1'b0;
      res_hit_r          <= 1'b0;
      res_handle_r       <= '0;
      res_disp_r         <= DISP_NONE;
      mod_x_r            <= '0;
      mod_rem_r          <= '0;
      mod_cnt_r          <= '0;
      out_valid_r        <= 1'b0;
      out_hit_r          <= 1'b0;
      out_found_handle_r <= '0;
      out_fill_level_r   <= '0;
      out_displaced_r    <= DISP_NONE;
    end else begin
      launch_r <= launch_nxt;
      if (out_valid_r && !out_stall && (state_r != S_WAIT)) begin
        out_valid_r <= 1'b0;
      end

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STORE_PERIOD: store_period_r <= cfg_wdata;
          CFG_MAX_ENTRIES:  max_entries_r  <= cfg_wdata[MAXENT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r        <= in_stamp;
            res_hit_r    <= 1'b0;
            res_handle_r <= '0;
            if (in_operation == OP_STORE) begin
              count_r    <= count_nxt;
              drop_r     <= drop;
              fetch_r    <= 1'b1;
              mod_x_r    <= dec_r + PERIOD_W'(1);
              mod_rem_r  <= '0;
              mod_cnt_r  <= '0;
              if (drop) begin
                head_r <= head_inc;
              end
              if (overwrite) begin
                res_disp_r <= DISP_OVERWRITE;
              end else if (drop) begin
                res_disp_r <= DISP_DROP;
              end else begin
                res_disp_r <= DISP_NONE;
              end
              state_r <= S_MOD;
            end else begin
              fetch_r    <= 1'b0;
              res_disp_r <= DISP_NONE;
              if (in_stamp >= oldest_r) begin
                state_r <= S_PASS;
              end else begin
                state_r <= S_WAIT;
              end
            end
          end
        end

        S_MOD: begin
          mod_rem_r <= mod_step[PERIOD_W-1:0];
          mod_x_r   <= {mod_x_r[PERIOD_W-2:0], 1'b0};
          mod_cnt_r <= mod_cnt_r + MCNT_W'(1);
          if (mod_cnt_r == MCNT_W'(MOD_STEPS - 1)) begin
            dec_r <= mod_step[PERIOD_W-1:0];
            if (drop_r) begin
              state_r <= S_PASS;
            end else begin
              state_r <= S_WAIT;
            end
          end
        end

        S_PASS: begin
          // token leaves the last cell
          if (tap_ctl[RING_DEPTH].active) begin
            if (fetch_r) begin
              oldest_r <= tap_stamp[RING_DEPTH];
            end else begin
              res_hit_r    <= tap_ctl[RING_DEPTH].hit;
              res_handle_r <= HANDLE_W'(tap_handle[RING_DEPTH]);
            end
            state_r <= S_WAIT;
          end
        end

        S_WAIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r        <= 1'b1;
            out_hit_r          <= res_hit_r;
            out_found_handle_r <= res_handle_r;
            out_fill_level_r   <= FILL_W'(count_r);
            out_displaced_r    <= res_disp_r;
            state_r            <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_handle = out_found_handle_r;
  assign out_fill_level   = out_fill_level_r;
  assign out_displaced    = out_displaced_r;

endmodule
